>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/pfd_pkg.sv
`default_nettype none

package pfd_pkg;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Field flag bits of the flags byte.
    localparam logic [3:0] FLAG_FLOW   = 4'h1;
    localparam logic [3:0] FLAG_URL    = 4'h2;
    localparam logic [3:0] FLAG_DOMAIN = 4'h4;
    localparam logic [3:0] FLAG_CUSTOM = 4'h8;

    localparam logic [1:0] FIELD_FLOW   = 2'd0;
    localparam logic [1:0] FIELD_URL    = 2'd1;
    localparam logic [1:0] FIELD_DOMAIN = 2'd2;
    localparam logic [1:0] FIELD_CUSTOM = 2'd3;

    typedef enum logic [2:0] {
        PH_FLAGS   = 3'd0,
        PH_SPARE   = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TRAIL   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_OK    = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] field_id;
        logic [7:0] data;
        logic       field_end;
        logic       run_last;
    } t_result;

    // Results produced by one accepted request: up to a field result and a status.
    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    s_valid;
        t_result s;
    } t_push;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_fifo_status;

    typedef struct packed {
        t_phase phase;
    } t_step_status;

endpackage

`default_nettype wire

>>> rtl/pfd_step.sv
`default_nettype none

module pfd_step (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_in_byte,
    input  wire logic                  i_last_byte,
    input  wire logic                  i_empty_value,
    output pfd_pkg::t_push             o_push,
    output pfd_pkg::t_step_status      o_status
);

    pfd_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_pending, n_pending;
    logic [1:0]      r_field, n_field;
    logic [7:0]      r_len_hi, n_len_hi;
    logic [15:0]     r_left, n_left;

    logic            nf_found;
    logic [1:0]      nf_field;
    logic [3:0]      nf_flags;
    logic [15:0]     left_dec;
    logic            a_valid;
    pfd_pkg::t_result a_res;
    pfd_pkg::t_result s_res;

    // Lowest pending flag picks the next field.
    always_comb begin
        nf_found = 1'b1;
        nf_field = pfd_pkg::FIELD_FLOW;
        nf_flags = r_pending;
        if ((r_pending & pfd_pkg::FLAG_FLOW) != 4'h0) begin
            nf_field = pfd_pkg::FIELD_FLOW;
            nf_flags = r_pending & ~pfd_pkg::FLAG_FLOW;
        end else if ((r_pending & pfd_pkg::FLAG_URL) != 4'h0) begin
            nf_field = pfd_pkg::FIELD_URL;
            nf_flags = r_pending & ~pfd_pkg::FLAG_URL;
        end else if ((r_pending & pfd_pkg::FLAG_DOMAIN) != 4'h0) begin
            nf_field = pfd_pkg::FIELD_DOMAIN;
            nf_flags = r_pending & ~pfd_pkg::FLAG_DOMAIN;
        end else if ((r_pending & pfd_pkg::FLAG_CUSTOM) != 4'h0) begin
            nf_field = pfd_pkg::FIELD_CUSTOM;
            nf_flags = r_pending & ~pfd_pkg::FLAG_CUSTOM;
        end else begin
            nf_found = 1'b0;
        end
    end

    assign left_dec = r_left - 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_field   = r_field;
        n_len_hi  = r_len_hi;
        n_left    = r_left;
        a_valid   = 1'b0;
        a_res     = '{kind: pfd_pkg::KIND_BYTE, field_id: r_field, data: 8'h00,
                      field_end: 1'b0, run_last: 1'b0};
        s_res     = '{kind: pfd_pkg::KIND_BAD, field_id: 2'd0, data: 8'h00,
                      field_end: 1'b0, run_last: 1'b1};

        unique case (r_phase)
            pfd_pkg::PH_FLAGS: begin
                n_pending = i_in_byte[3:0];
                n_phase   = pfd_pkg::PH_SPARE;
            end
            pfd_pkg::PH_SPARE: begin
                if (nf_found) begin
                    n_pending = nf_flags;
                    n_field   = nf_field;
                    n_phase   = pfd_pkg::PH_LEN_HI;
                end else begin
                    n_phase = pfd_pkg::PH_TRAIL;
                end
            end
            pfd_pkg::PH_LEN_HI: begin
                n_len_hi = i_in_byte;
                n_phase  = pfd_pkg::PH_LEN_LO;
            end
            pfd_pkg::PH_LEN_LO: begin
                if ({r_len_hi, i_in_byte} == 16'h0000) begin
                    a_valid    = 1'b1;
                    a_res.kind = pfd_pkg::KIND_EMPTY;
                    if (nf_found) begin
                        n_pending = nf_flags;
                        n_field   = nf_field;
                        n_phase   = pfd_pkg::PH_LEN_HI;
                    end else begin
                        n_phase = pfd_pkg::PH_TRAIL;
                    end
                end else begin
                    n_left  = {r_len_hi, i_in_byte};
                    n_phase = pfd_pkg::PH_PAYLOAD;
                end
            end
            pfd_pkg::PH_PAYLOAD: begin
                n_left          = left_dec;
                a_valid         = 1'b1;
                a_res.data      = i_in_byte;
                a_res.field_end = (left_dec == 16'h0000);
                if (left_dec == 16'h0000) begin
                    if (nf_found) begin
                        n_pending = nf_flags;
                        n_field   = nf_field;
                        n_phase   = pfd_pkg::PH_LEN_HI;
                    end else begin
                        n_phase = pfd_pkg::PH_TRAIL;
                    end
                end
            end
            default: begin
            end
        endcase

        // The status is judged on the phase this byte leaves behind.
        if (n_phase == pfd_pkg::PH_TRAIL) begin
            s_res.kind = pfd_pkg::KIND_OK;
        end
        a_res.run_last = !i_last_byte;

        if (i_empty_value) begin
            a_valid    = 1'b0;
            s_res.kind = pfd_pkg::KIND_BAD;
        end

        // End of value, either way, returns every state field to reset.
        if (i_empty_value || i_last_byte) begin
            n_phase   = pfd_pkg::PH_FLAGS;
            n_pending = 4'h0;
            n_field   = 2'd0;
            n_len_hi  = 8'h00;
            n_left    = 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pfd_pkg::PH_FLAGS;
            r_pending <= 4'h0;
            r_field   <= 2'd0;
            r_len_hi  <= 8'h00;
            r_left    <= 16'h0000;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_field   <= n_field;
            r_len_hi  <= n_len_hi;
            r_left    <= n_left;
        end
    end

    assign o_push.a_valid = i_accept && a_valid;
    assign o_push.a       = a_res;
    assign o_push.s_valid = i_accept && (i_empty_value || i_last_byte);
    assign o_push.s       = s_res;
    assign o_status.phase = r_phase;

endmodule

`default_nettype wire

>>> rtl/pfd_res_fifo.sv
`default_nettype none

module pfd_res_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pfd_pkg::t_push        i_push,
    input  wire logic                  i_pop,
    output pfd_pkg::t_result           o_head,
    output pfd_pkg::t_fifo_status      o_status
);

    localparam int AW = pfd_pkg::FIFO_AW;
    localparam int CW = pfd_pkg::CNT_W;

    pfd_pkg::t_result r_mem [pfd_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    logic             wr0, wr1;
    pfd_pkg::t_result e0;
    logic [AW-1:0]    wptr1;
    logic [CW-1:0]    push_n;

    // A lone status goes into the first slot; with a field result it follows it.
    assign wr0    = i_push.a_valid || i_push.s_valid;
    assign wr1    = i_push.a_valid && i_push.s_valid;
    assign e0     = i_push.a_valid ? i_push.a : i_push.s;
    assign wptr1  = r_wptr + AW'(1);
    assign push_n = CW'(wr0) + CW'(wr1);

    always_comb begin
        n_wptr  = r_wptr + AW'(push_n);
        n_rptr  = i_pop ? r_rptr + AW'(1) : r_rptr;
        n_count = r_count + push_n - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (wr0) begin
            r_mem[r_wptr] <= e0;
        end
        if (wr1) begin
            r_mem[wptr1] <= i_push.s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    assign o_head         = r_mem[r_rptr];
    assign o_status.count = r_count;

endmodule

`default_nettype wire

>>> rtl/pfd_contents_decoder.sv
// Streaming decoder for a packet-detection contents value. Bytes of the value
// arrive one request at a time: a flags byte, a spare byte that is skipped, and
// then for each of flag bits 0 to 3 that is set (flow description, URL, domain
// name, custom content, in that order) a 16-bit big-endian length followed by
// that many payload bytes. Each payload byte leaves as a result tagged with its
// field, the last one of a field carrying field_end; a zero-length field gives
// one empty-field result. The request marked last_byte, or any request with
// empty_value set, also yields a status result, ok or malformed, after which
// the decoder is back in its reset state. On malformed the consumer should
// drop the bytes delivered for that value. The decoder takes one request per
// clock cycle while ready is high, and its results are registered. Most requests
// give zero or one result; a final byte that also carries a payload byte or an
// empty marker gives two, which leave one after the other through the single
// read port of the four-entry result queue. Input ready stays high while that
// queue holds two results or fewer. With an always-ready consumer the input
// never pauses at one request per cycle: every double result is preceded by at
// least three requests of its value that give no result, which drain the queue.

`default_nettype none

`include "assert_macros.svh"

module pfd_contents_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input request channel.
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_empty_value,
    // Result channel.
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_result_kind,
    output logic [1:0]      o_field_id,
    output logic [7:0]      o_data_byte,
    output logic            o_field_end,
    output logic            o_run_last
);

    localparam int CW = pfd_pkg::CNT_W;

    pfd_pkg::t_push        push;
    pfd_pkg::t_step_status step_status;
    pfd_pkg::t_fifo_status fifo_status;
    pfd_pkg::t_result      head;
    logic                  in_accept;
    logic                  out_accept;

    // Room for two results is reserved before a request is taken, so the
    // queue can never overflow whatever the consumer does.
    assign o_ready    = fifo_status.count <= CW'(pfd_pkg::FIFO_DEPTH - 2);
    assign in_accept  = i_valid && o_ready;
    assign o_valid    = fifo_status.count != '0;
    assign out_accept = o_valid && i_ready;

    pfd_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_in_byte     (i_in_byte),
        .i_last_byte   (i_last_byte),
        .i_empty_value (i_empty_value),
        .o_push        (push),
        .o_status      (step_status)
    );

    pfd_res_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (out_accept),
        .o_head   (head),
        .o_status (fifo_status)
    );

    assign o_result_kind = head.kind;
    assign o_field_id    = head.field_id;
    assign o_data_byte   = head.data;
    assign o_field_end   = head.field_end;
    assign o_run_last    = head.run_last;

    // Checks on the decoder's own bookkeeping.
    `ASSERT_ALWAYS(a_fifo_bound, i_clk, i_rst_n, fifo_status.count <= CW'(pfd_pkg::FIFO_DEPTH), "result queue overflow")
    `ASSERT_IMPLY(a_status_last, i_clk, i_rst_n, o_valid && (head.kind == pfd_pkg::KIND_OK || head.kind == pfd_pkg::KIND_BAD), o_run_last, "status result without run_last")
    `ASSERT_IMPLY(a_end_on_byte, i_clk, i_rst_n, o_valid && o_field_end, head.kind == pfd_pkg::KIND_BYTE, "field_end on a non-payload result")
    `ASSERT_NEXT(a_value_reset, i_clk, i_rst_n, in_accept && (i_last_byte || i_empty_value), step_status.phase == pfd_pkg::PH_FLAGS, "decoder not back at flags after end of value")

endmodule

`default_nettype wire
